// ===== rtl/char_device_ring_buffer_defines.svh =====
// assertion macros for the character device ring buffer
`ifndef CHAR_DEVICE_RING_BUFFER_DEFINES_SVH
`define CHAR_DEVICE_RING_BUFFER_DEFINES_SVH

// checked on every clock edge outside reset
`define CRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define CRB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/crb_pkg.sv =====
// shared types, constants and helper functions of the ring buffer
package crb_pkg;

  localparam int unsigned MAX_LOG_DEPTH = 10;
  localparam int unsigned ELEM_WIDTH    = 32;
  localparam int unsigned DEPTH         = 1 << MAX_LOG_DEPTH;
  localparam int unsigned POS_W         = MAX_LOG_DEPTH;
  localparam int unsigned CNT_W         = MAX_LOG_DEPTH + 1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_FLUSH = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ERROR     = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_ENABLE    = 2'd0,
    CFG_LOG_DEPTH = 2'd1,
    CFG_LOG_BYTES = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic       enabled;
    logic [3:0] log_depth;
    logic [1:0] log_elem_bytes;
  } cfg_t;

  typedef struct packed {
    logic                  we;
    logic                  re;
    logic [POS_W-1:0]      addr;
    logic [ELEM_WIDTH-1:0] wdata;
  } mem_req_t;

  // elements held at the current setting, zero when buffering is off
  function automatic logic [CNT_W-1:0] cap_of(cfg_t cfg);
    logic [3:0] ld;
    ld = (32'(cfg.log_depth) > MAX_LOG_DEPTH) ? 4'(MAX_LOG_DEPTH) : cfg.log_depth;
    return cfg.enabled ? (CNT_W'(1) << ld) : '0;
  endfunction

  // element mask, size code three counts as four bytes
  function automatic logic [ELEM_WIDTH-1:0] mask_of(cfg_t cfg);
    logic [1:0]  lb;
    int unsigned bits;
    lb   = (cfg.log_elem_bytes > 2'd2) ? 2'd2 : cfg.log_elem_bytes;
    bits = 8 << lb;
    if (bits >= ELEM_WIDTH) begin
      return '1;
    end
    return (ELEM_WIDTH'(1) << bits) - ELEM_WIDTH'(1);
  endfunction

endpackage

// ===== rtl/crb_mem.sv =====
// element store: single port synchronous ram with registered read data
module crb_mem (
  input  logic                               clk_i,
  input  crb_pkg::mem_req_t                  req_i,
  output logic [crb_pkg::ELEM_WIDTH-1:0]     rdata_o
);
  import crb_pkg::*;

  logic [ELEM_WIDTH-1:0] mem_q [DEPTH];
  logic [ELEM_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/crb_ctrl.sv =====
// ring buffer control: positions, fill count, sequencing and result register
module crb_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  crb_pkg::cfg_t                     cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        operation_i,
  input  logic [31:0]                       write_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic [31:0]                       read_data_o,
  output logic [10:0]                       fill_count_o,
  output logic [10:0]                       capacity_o,
  output logic                              is_enabled_o,
  output crb_pkg::mem_req_t                 mem_req_o,
  input  logic [crb_pkg::ELEM_WIDTH-1:0]    mem_rdata_i
);
  import crb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

  state_e           state_q, state_d;
  logic [POS_W-1:0] rd_pos_q, rd_pos_d;
  logic [POS_W-1:0] wr_pos_q, wr_pos_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  logic [1:0]       status_q, status_d;
  logic [31:0]      rdata_q, rdata_d;
  logic [10:0]      fill_q, fill_d;
  logic [10:0]      cap_q, cap_d;
  logic             en_q, en_d;

  logic [CNT_W-1:0]      cap;
  logic [CNT_W-1:0]      pos_wrap;
  logic [ELEM_WIDTH-1:0] mask;
  logic                  accept;
  op_e                   op;

  assign cap      = cap_of(cfg_i);
  assign pos_wrap = cap - CNT_W'(1);
  assign mask     = mask_of(cfg_i);
  assign op       = op_e'(operation_i);

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    rd_pos_d    = rd_pos_q;
    wr_pos_d    = wr_pos_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    rdata_d     = rdata_q;
    fill_d      = fill_q;
    cap_d       = cap_q;
    en_d        = en_q;
    mem_req_o   = '{we: 1'b0, re: 1'b0, addr: wr_pos_q,
                    wdata: ELEM_WIDTH'(write_data_i) & mask};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = ST_OK;
          rdata_d  = '0;
          case (op)
            OP_WRITE: begin
              if (!cfg_i.enabled || cnt_q >= cap) begin
                status_d = ST_ERROR;
              end else begin
                mem_req_o.we   = 1'b1;
                mem_req_o.addr = wr_pos_q;
                wr_pos_d = POS_W'((CNT_W'(wr_pos_q) + CNT_W'(1)) & pos_wrap);
                cnt_d    = cnt_q + CNT_W'(1);
              end
            end
            OP_READ: begin
              if (!cfg_i.enabled || cnt_q == '0) begin
                status_d = ST_UNDERFLOW;
              end else begin
                mem_req_o.re   = 1'b1;
                mem_req_o.addr = rd_pos_q;
                rd_pos_d = POS_W'((CNT_W'(rd_pos_q) + CNT_W'(1)) & pos_wrap);
                cnt_d    = cnt_q - CNT_W'(1);
                state_d  = S_READ;
              end
            end
            OP_FLUSH: begin
              rd_pos_d = '0;
              wr_pos_d = '0;
              cnt_d    = '0;
            end
            default: ;
          endcase
          // a popped word is delivered once the ram has answered
          if (!mem_req_o.re) begin
            out_valid_d = 1'b1;
            fill_d      = 11'(cnt_d);
            cap_d       = 11'(cap);
            en_d        = cfg_i.enabled;
          end
        end
      end
      S_READ: begin
        out_valid_d = 1'b1;
        status_d    = ST_OK;
        rdata_d     = 32'(mem_rdata_i & mask);
        fill_d      = 11'(cnt_q);
        cap_d       = 11'(cap);
        en_d        = cfg_i.enabled;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_pos_q    <= '0;
      wr_pos_q    <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_pos_q    <= rd_pos_d;
      wr_pos_q    <= wr_pos_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    rdata_q  <= rdata_d;
    fill_q   <= fill_d;
    cap_q    <= cap_d;
    en_q     <= en_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign read_data_o  = rdata_q;
  assign fill_count_o = fill_q;
  assign capacity_o   = cap_q;
  assign is_enabled_o = en_q;

endmodule

// ===== rtl/char_device_ring_buffer.sv =====
// Character device ring buffer: a FIFO of 2^log_depth elements (up to 1024) of 1, 2 or 4
// bytes held in one single-port synchronous RAM. Each word on the input channel is a
// write, a read or a flush and gives exactly one result word with status, popped data,
// fill count, capacity and the enabled flag. Writes, flushes, rejected operations and
// unused codes have their result registered on acceptance; a successful read first
// passes the RAM's read register and S_READ. One operation is in flight at a time and
// the next is accepted once the previous result is in the output register and leaving.
// The store is not cleared after reset: no clearing pass, ready at once. The user must
// keep configuration writes via cfg_we_i/cfg_index_i/cfg_data_i to idle; not enforced.
`include "char_device_ring_buffer_defines.svh"

module char_device_ring_buffer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] read_data_o,
  output logic [10:0] fill_count_o,
  output logic [10:0] capacity_o,
  output logic        is_enabled_o
);
  import crb_pkg::*;

  cfg_t                  cfg_q, cfg_d;
  mem_req_t              mem_req;
  logic [ELEM_WIDTH-1:0] mem_rdata;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ENABLE:    cfg_d.enabled        = cfg_data_i[0];
        CFG_LOG_DEPTH: cfg_d.log_depth      = cfg_data_i;
        CFG_LOG_BYTES: cfg_d.log_elem_bytes = cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  crb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .read_data_o  (read_data_o),
    .fill_count_o (fill_count_o),
    .capacity_o   (capacity_o),
    .is_enabled_o (is_enabled_o),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata)
  );

  crb_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // ram port carries one access at a time
  `CRB_ASSERT_ALWAYS(a_single_access, !(mem_req.we && mem_req.re), "ram read and write together")
  // the store is only touched for an accepted word
  `CRB_ASSERT(a_access_on_accept, (mem_req.we || mem_req.re) |-> (in_valid_i && in_ready_o),
              "ram access without an accepted word")
  // a popped word reaches the output register after the ram read register and S_READ
  `CRB_ASSERT(a_read_result, mem_req.re |=> ##1 out_valid_o, "read result not delivered")

endmodule

// ===== dv/char_device_ring_buffer_test.sv =====
// self-checking testbench for the character device ring buffer
module char_device_ring_buffer_test;
  import crb_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam logic [31:0] EDGE_DATA [0:7] = '{
    32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001,
    32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'h0000_FFFF, 32'hFFFF_0000
  };

  typedef struct {
    status_e          status;
    logic [31:0]      rdata;
    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] cap;
    logic             en;
  } ring_result_t;

  // keeps its own copy of the buffer and queues the result of each accepted word
  class ring_scoreboard;
    logic [31:0]      store [DEPTH];
    logic [POS_W-1:0] rd_pos;
    logic [POS_W-1:0] wr_pos;
    logic [CNT_W-1:0] held;
    logic             en;
    logic [3:0]       log_depth;
    logic [1:0]       log_bytes;
    ring_result_t     awaited_q [$];
    int               failures;

    function new();
      rd_pos    = '0;
      wr_pos    = '0;
      held      = '0;
      en        = 1'b0;
      log_depth = '0;
      log_bytes = '0;
      failures  = 0;
    endfunction

    function logic [CNT_W-1:0] capacity();
      int unsigned depth_bits;
      depth_bits = (log_depth > MAX_LOG_DEPTH) ? MAX_LOG_DEPTH : int'(log_depth);
      return en ? CNT_W'(1 << depth_bits) : '0;
    endfunction

    function logic [31:0] elem_mask();
      case (log_bytes)
        2'd0:    return 32'h0000_00FF;
        2'd1:    return 32'h0000_FFFF;
        default: return 32'hFFFF_FFFF;
      endcase
    endfunction

    function void note_config(cfg_idx_e idx, logic [3:0] value);
      case (idx)
        CFG_ENABLE:    en = value[0];
        CFG_LOG_DEPTH: log_depth = value;
        CFG_LOG_BYTES: log_bytes = value[1:0];
        default:       ;
      endcase
    endfunction

    function void note_word(logic [1:0] op, logic [31:0] data);
      ring_result_t     r;
      logic [CNT_W-1:0] cap;
      logic [31:0]      mask;
      cap      = capacity();
      mask     = elem_mask();
      r.status = ST_OK;
      r.rdata  = '0;
      case (op)
        OP_WRITE: begin
          if (!en || held >= cap) begin
            r.status = ST_ERROR;
          end else begin
            store[wr_pos] = data & mask;
            wr_pos = POS_W'((32'(wr_pos) + 1) & (32'(cap) - 1));
            held   = held + 1'b1;
          end
        end
        OP_READ: begin
          if (!en || held == 0) begin
            r.status = ST_UNDERFLOW;
          end else begin
            r.rdata = store[rd_pos] & mask;
            rd_pos  = POS_W'((32'(rd_pos) + 1) & (32'(cap) - 1));
            held    = held - 1'b1;
          end
        end
        OP_FLUSH: begin
          rd_pos = '0;
          wr_pos = '0;
          held   = '0;
        end
        default: ;
      endcase
      r.fill = held;
      r.cap  = cap;
      r.en   = en;
      awaited_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (act_val !== exp_val) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
        failures++;
      end
    endfunction

    function void check_result(logic [1:0] status, logic [31:0] rdata, logic [10:0] fill,
                               logic [10:0] cap, logic en_flag);
      ring_result_t e;
      if (awaited_q.size() == 0) begin
        $display("%0t: result word with none expected, expected nothing, actual status %0d",
                 $time, status);
        failures++;
        return;
      end
      e = awaited_q.pop_front();
      compare_field("status", 32'(e.status), 32'(status));
      compare_field("read_data", e.rdata, rdata);
      compare_field("fill_count", 32'(e.fill), 32'(fill));
      compare_field("capacity", 32'(e.cap), 32'(cap));
      compare_field("is_enabled", 32'(e.en), 32'(en_flag));
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [3:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  operation_i;
  logic [31:0] write_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [31:0] read_data_o;
  logic [10:0] fill_count_o;
  logic [10:0] capacity_o;
  logic        is_enabled_o;

  ring_scoreboard board = new();
  logic [3:0]     cur_log_depth = '0;
  int             burst_left = 0;
  int             hold_requests = 0;

  char_device_ring_buffer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .read_data_o  (read_data_o),
    .fill_count_o (fill_count_o),
    .capacity_o   (capacity_o),
    .is_enabled_o (is_enabled_o)
  );

  always #4 clk_i = ~clk_i;

  // offer one word, idling between bursts, and note it once taken
  task automatic send_word(logic [1:0] op, logic [31:0] data);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    write_data_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_word(op, data);
    burst_left--;
  endtask

  // drain every outstanding result, then give a read in flight time to finish
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [3:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    board.note_config(idx, value);
  endtask

  task automatic apply_settings(logic en, logic [3:0] log_depth, logic [1:0] log_bytes);
    write_reg(CFG_ENABLE, {3'b000, en});
    write_reg(CFG_LOG_DEPTH, log_depth);
    write_reg(CFG_LOG_BYTES, {2'b00, log_bytes});
    cfg_we_i      <= 1'b0;
    cur_log_depth = log_depth;
  endtask

  function automatic logic [31:0] pick_data();
    case ($urandom_range(0, 9))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_phase(logic en, logic [3:0] log_depth, logic [1:0] log_bytes,
                           int wr_pct, int rd_pct, int n_words, bit squeeze);
    int         r;
    logic [1:0] op;
    settle();
    // a new depth would expose stale positions, so empty the buffer first
    if (log_depth != cur_log_depth) begin
      send_word(OP_FLUSH, pick_data());
      settle();
    end
    apply_settings(en, log_depth, log_bytes);
    if (squeeze) begin
      hold_requests++;
    end
    repeat (n_words) begin
      r = $urandom_range(0, 99);
      if (r < wr_pct) begin
        op = OP_WRITE;
      end else if (r < wr_pct + rd_pct) begin
        op = OP_READ;
      end else if (r < 99) begin
        op = OP_FLUSH;
      end else begin
        op = OP_UNUSED;
      end
      send_word(op, pick_data());
    end
  endtask

  // receiver: segments of steady, random, sparse and stalled ready, plus one long hold
  initial begin
    int seg_left;
    int seg_mode;
    int holds_done;
    logic rdy;
    out_ready_i = 1'b0;
    seg_left    = 0;
    seg_mode    = 0;
    holds_done  = 0;
    @(posedge clk_i);
    forever begin
      if (hold_requests != holds_done) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        holds_done = hold_requests;
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 3);
          seg_left = $urandom_range(1, 40);
        end
        case (seg_mode)
          0:       rdy = 1'b1;
          1:       rdy = 1'($urandom_range(0, 1));
          2:       rdy = (seg_left % 3 == 0);
          default: rdy = 1'b0;
        endcase
        out_ready_i <= rdy;
        seg_left--;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_result(status_o, read_data_o, fill_count_o, capacity_o, is_enabled_o);
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = CFG_ENABLE;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    operation_i  = OP_WRITE;
    write_data_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // out of reset the buffer is off: rejected write, underflow, flush, unused code
    send_word(OP_WRITE, 32'hFFFF_FFFF);
    send_word(OP_READ, 32'h0000_0000);
    send_word(OP_FLUSH, 32'h0000_0000);
    send_word(OP_UNUSED, 32'h1234_5678);
    settle();

    // fill eight four-byte elements, then overfill
    apply_settings(1'b1, 4'd3, 2'd2);
    foreach (EDGE_DATA[i]) begin
      send_word(OP_WRITE, EDGE_DATA[i]);
    end
    send_word(OP_WRITE, 32'hFFFF_FFFF);
    send_word(OP_UNUSED, 32'hFFFF_FFFF);
    settle();

    // shrink the depth with data held: reads wrap on two slots, writes stay rejected
    apply_settings(1'b1, 4'd1, 2'd0);
    repeat (3) send_word(OP_READ, 32'h0000_0000);
    send_word(OP_WRITE, 32'hFFFF_FFFF);
    send_word(OP_FLUSH, 32'h0000_0000);
    send_word(OP_READ, 32'h0000_0000);

    run_phase(1'b1, 4'd2,  2'd0, 60, 38, 120, 1'b0);
    run_phase(1'b1, 4'd2,  2'd2, 45, 53, 120, 1'b0);
    run_phase(1'b0, 4'd2,  2'd2, 50, 48,  40, 1'b0);
    run_phase(1'b1, 4'd2,  2'd1, 40, 58,  80, 1'b0);
    run_phase(1'b1, 4'd0,  2'd3, 55, 43, 120, 1'b0);
    run_phase(1'b1, 4'd4,  2'd2, 70, 28, 150, 1'b1);
    run_phase(1'b1, 4'd4,  2'd0, 30, 68, 100, 1'b0);
    run_phase(1'b1, 4'd10, 2'd2, 65, 33, 150, 1'b0);
    run_phase(1'b1, 4'd15, 2'd1, 50, 48, 100, 1'b0);
    run_phase(1'b1, 4'd1,  2'd2, 55, 43, 120, 1'b0);
    settle();

    if (board.failures == 0 && board.pending() == 0) begin
      $display("char_device_ring_buffer_test passed");
    end else begin
      $display("char_device_ring_buffer_test failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("char_device_ring_buffer_test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/crb_pkg.sv
rtl/crb_mem.sv
rtl/crb_ctrl.sv
rtl/char_device_ring_buffer.sv
dv/char_device_ring_buffer_test.sv
